// ===== rtl/core/baro_pressure_temp_compensation_defines.svh =====
// Assertion macros shared by the barometer compensation RTL.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPTC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bptc_pkg.sv =====
// Types and constants shared by the barometer compensation pipeline.
package bptc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_PRESSURE_SENSITIVITY  = 3'd0;
	localparam logic [2:0] CFG_PRESSURE_OFFSET       = 3'd1;
	localparam logic [2:0] CFG_SENS_TEMP_COEF        = 3'd2;
	localparam logic [2:0] CFG_OFFSET_TEMP_COEF      = 3'd3;
	localparam logic [2:0] CFG_REFERENCE_TEMPERATURE = 3'd4;
	localparam logic [2:0] CFG_TEMP_SENSITIVITY_COEF = 3'd5;

	// Temperature thresholds in centidegrees.
	localparam logic signed [19:0] COLD_LIMIT      = 20'sd2000;
	// Distance from the cold limit down to the very cold limit.
	localparam logic signed [18:0] VERY_COLD_SPAN  = 19'sd3500;

	// Scaling shifts of the compensation formulas.
	localparam int unsigned OFF_TC_SHIFT  = 7;
	localparam int unsigned SENS_TC_SHIFT = 8;
	localparam int unsigned TEMP_SHIFT    = 23;
	localparam int unsigned T2_SHIFT      = 31;
	localparam int unsigned PROD_SHIFT    = 21;
	localparam int unsigned PRESS_SHIFT   = 15;
	localparam int unsigned SENS_LO_W     = 20;

	// One input item: raw conversions.
	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic signed [31:0] comp_pressure;
		logic signed [19:0] temperature_centi;
	} out_item_t;

	// Factory calibration words.
	typedef struct packed {
		logic [15:0] pressure_sensitivity;
		logic [15:0] pressure_offset;
		logic [15:0] sens_temp_coef;
		logic [15:0] offset_temp_coef;
		logic [15:0] reference_temperature;
		logic [15:0] temp_sensitivity_coef;
	} cal_t;

	// First-order results handed to the correction stages.
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [39:0] off;
		logic signed [39:0] sens;
		logic signed [18:0] tdiff;
		logic signed [18:0] tcold;
		logic [16:0]        t2;
	} first_t;

	// Corrected values handed to the pressure stages.
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [39:0] off;
		logic signed [39:0] sens;
		logic signed [19:0] temp;
	} second_t;

endpackage

// ===== rtl/core/bptc_first.sv =====
// First-order stages: temperature difference, offset, sensitivity and temperature.
`include "baro_pressure_temp_compensation_defines.svh"

module bptc_first (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bptc_pkg::in_item_t in_item,
	input  bptc_pkg::cal_t    cal,
	output bptc_pkg::first_t  fo
);

	logic               v_s1, v_s2, v_s3;
	logic [23:0]        d1_s1, d1_s2, d1_s3;
	logic signed [24:0] dt_s1;
	logic signed [41:0] offm_s2, sensm_s2, tm_s2;
	logic signed [49:0] dsq_s2;
	logic signed [39:0] off_s3, sens_s3;
	logic signed [18:0] tdiff_s3, tcold_s3;
	logic [16:0]        t2_s3;
	logic signed [18:0] tdiff_c;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: temperature difference against the reference.
	always_ff @(posedge clk) begin
		d1_s1 <= in_item.raw_pressure;
		dt_s1 <= $signed({1'b0, in_item.raw_temperature})
			- $signed({1'b0, cal.reference_temperature, 8'h00});
	end

	// Stage 2: the four products of the temperature difference.
	always_ff @(posedge clk) begin
		d1_s2    <= d1_s1;
		offm_s2  <= $signed({1'b0, cal.offset_temp_coef}) * dt_s1;
		sensm_s2 <= $signed({1'b0, cal.sens_temp_coef}) * dt_s1;
		tm_s2    <= dt_s1 * $signed({1'b0, cal.temp_sensitivity_coef});
		dsq_s2   <= dt_s1 * dt_s1;
	end

	// Temperature minus the cold limit, floor-shifted.
	assign tdiff_c = 19'(tm_s2 >>> bptc_pkg::TEMP_SHIFT);

	// Stage 3: scale and sum the first-order terms.
	always_ff @(posedge clk) begin
		d1_s3    <= d1_s2;
		off_s3   <= $signed({8'h00, cal.pressure_offset, 16'h0000})
			+ 40'(offm_s2 >>> bptc_pkg::OFF_TC_SHIFT);
		sens_s3  <= $signed({9'h000, cal.pressure_sensitivity, 15'h0000})
			+ 40'(sensm_s2 >>> bptc_pkg::SENS_TC_SHIFT);
		tdiff_s3 <= tdiff_c;
		tcold_s3 <= tdiff_c + bptc_pkg::VERY_COLD_SPAN;
		t2_s3    <= dsq_s2[bptc_pkg::T2_SHIFT +: 17];
	end

	assign fo.valid = v_s3;
	assign fo.d1    = d1_s3;
	assign fo.off   = off_s3;
	assign fo.sens  = sens_s3;
	assign fo.tdiff = tdiff_s3;
	assign fo.tcold = tcold_s3;
	assign fo.t2    = t2_s3;

	// Very cold always implies cold.
	`BPTC_ASSERT_SAME(a_very_cold_is_cold, v_s3 && (tcold_s3 < 0), tdiff_s3 < 0,
		"very cold item not flagged cold")

endmodule

// ===== rtl/core/bptc_second.sv =====
// Second-order correction stages for cold and very cold temperatures.
`include "baro_pressure_temp_compensation_defines.svh"

module bptc_second (
	input  logic              clk,
	input  logic              arst_n,
	input  bptc_pkg::first_t  fi,
	output bptc_pkg::second_t so
);

	logic               v_s4, v_s5, v_s6;
	logic [23:0]        d1_s4, d1_s5, d1_s6;
	logic signed [39:0] off_s4, off_s5, off_s6;
	logic signed [39:0] sens_s4, sens_s5, sens_s6;
	logic signed [19:0] temp_s4, temp_s5, temp_s6;
	logic [16:0]        t2_s4, t2_s5;
	logic               cold_s4, cold_s5, very_s4;
	logic signed [37:0] sq_s4, sqb_s4;
	logic [39:0]        off2_s5, sens2_s5;
	logic [39:0]        sq_w, sqb_w, five_sq, seven_sqb, eleven_sqb;
	logic [39:0]        off2_c, sens2_c;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= fi.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 4: squares of the distances below both limits.
	always_ff @(posedge clk) begin
		d1_s4   <= fi.d1;
		off_s4  <= fi.off;
		sens_s4 <= fi.sens;
		t2_s4   <= fi.t2;
		temp_s4 <= bptc_pkg::COLD_LIMIT + 20'(fi.tdiff);
		cold_s4 <= fi.tdiff[18];
		very_s4 <= fi.tcold[18];
		sq_s4   <= fi.tdiff * fi.tdiff;
		sqb_s4  <= fi.tcold * fi.tcold;
	end

	// Both squares are non-negative, so halving and quartering are shifts.
	assign sq_w       = 40'($unsigned(sq_s4));
	assign sqb_w      = 40'($unsigned(sqb_s4));
	assign five_sq    = sq_w + (sq_w << 2);
	assign seven_sqb  = (sqb_w << 3) - sqb_w;
	assign eleven_sqb = (sqb_w << 3) + (sqb_w << 1) + sqb_w;

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			off2_c  = five_sq >> 1;
			sens2_c = five_sq >> 2;
			if (very_s4) begin
				off2_c  = off2_c + seven_sqb;
				sens2_c = sens2_c + (eleven_sqb >> 1);
			end
		end
	end

	// Stage 5: correction terms.
	always_ff @(posedge clk) begin
		d1_s5    <= d1_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		temp_s5  <= temp_s4;
		t2_s5    <= t2_s4;
		cold_s5  <= cold_s4;
		off2_s5  <= off2_c;
		sens2_s5 <= sens2_c;
	end

	// Stage 6: apply the corrections.
	always_ff @(posedge clk) begin
		d1_s6   <= d1_s5;
		off_s6  <= off_s5 - $signed(off2_s5);
		sens_s6 <= sens_s5 - $signed(sens2_s5);
		temp_s6 <= cold_s5 ? (temp_s5 - $signed({3'b000, t2_s5})) : temp_s5;
	end

	assign so.valid = v_s6;
	assign so.d1    = d1_s6;
	assign so.off   = off_s6;
	assign so.sens  = sens_s6;
	assign so.temp  = temp_s6;

	// Corrections only ever lower the first-order values.
	`BPTC_ASSERT_NEXT(a_off_not_raised, v_s5, off_s6 <= $past(off_s5),
		"offset correction raised the offset")
	`BPTC_ASSERT_NEXT(a_sens_not_raised, v_s5, sens_s6 <= $past(sens_s5),
		"sensitivity correction raised the sensitivity")
	`BPTC_ASSERT_NEXT(a_temp_not_raised, v_s5, temp_s6 <= $past(temp_s5),
		"temperature correction raised the temperature")

endmodule

// ===== rtl/core/bptc_press.sv =====
// Pressure stages: split product of raw pressure and sensitivity, then scaling.
module bptc_press (
	input  logic                clk,
	input  logic                arst_n,
	input  bptc_pkg::second_t   si,
	output logic                done,
	output bptc_pkg::out_item_t result
);

	logic                   v_s7, v_s8, v_s9;
	logic [43:0]            pl_s7;
	logic signed [44:0]     ph_s7;
	logic signed [39:0]     off_s7, off_s8;
	logic signed [19:0]     temp_s7, temp_s8;
	logic signed [63:0]     prod_s8;
	logic signed [43:0]     press_c;
	bptc_pkg::out_item_t    result_s9;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s7 <= si.valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage 7: partial products against the low and high halves of the sensitivity.
	always_ff @(posedge clk) begin
		pl_s7   <= si.d1 * si.sens[bptc_pkg::SENS_LO_W-1:0];
		ph_s7   <= $signed({1'b0, si.d1}) * $signed(si.sens[39:bptc_pkg::SENS_LO_W]);
		off_s7  <= si.off;
		temp_s7 <= si.temp;
	end

	// Stage 8: recombine the full product.
	always_ff @(posedge clk) begin
		prod_s8 <= (64'(ph_s7) <<< bptc_pkg::SENS_LO_W) + $signed({20'h00000, pl_s7});
		off_s8  <= off_s7;
		temp_s8 <= temp_s7;
	end

	// Scaled product minus offset.
	assign press_c = 44'(prod_s8 >>> bptc_pkg::PROD_SHIFT) - 44'(off_s8);

	// Stage 9: output register, low 32 bits of the pressure.
	always_ff @(posedge clk) begin
		result_s9.comp_pressure     <= 32'(press_c >>> bptc_pkg::PRESS_SHIFT);
		result_s9.temperature_centi <= temp_s8;
	end

	assign done   = v_s9;
	assign result = result_s9;

endmodule

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// Top level of the barometer second-order temperature compensation pipeline.
// A result strobes on done when the accepted item leaves the stage 9 output register.
// Throughput: one item per cycle; busy stays low since the nine-stage pipeline never stalls.
// The 24x40 pressure product is split into two partial products over two stages.
// Reset clears the pipeline valid bits and all six calibration registers to zero.
`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bptc_pkg::in_item_t  sample,
	output logic                done,
	output bptc_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);

	bptc_pkg::cal_t    cal_q;
	bptc_pkg::first_t  first_res;
	bptc_pkg::second_t second_res;
	logic              accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Calibration register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bptc_pkg::CFG_PRESSURE_SENSITIVITY:  cal_q.pressure_sensitivity  <= cfg_wdata;
				bptc_pkg::CFG_PRESSURE_OFFSET:       cal_q.pressure_offset       <= cfg_wdata;
				bptc_pkg::CFG_SENS_TEMP_COEF:        cal_q.sens_temp_coef        <= cfg_wdata;
				bptc_pkg::CFG_OFFSET_TEMP_COEF:      cal_q.offset_temp_coef      <= cfg_wdata;
				bptc_pkg::CFG_REFERENCE_TEMPERATURE: cal_q.reference_temperature <= cfg_wdata;
				bptc_pkg::CFG_TEMP_SENSITIVITY_COEF: cal_q.temp_sensitivity_coef <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// First-order terms.
	bptc_first u_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(accept),
		.in_item (sample),
		.cal     (cal_q),
		.fo      (first_res)
	);

	// Second-order correction.
	bptc_second u_second (
		.clk   (clk),
		.arst_n(arst_n),
		.fi    (first_res),
		.so    (second_res)
	);

	// Pressure computation and output register.
	bptc_press u_press (
		.clk   (clk),
		.arst_n(arst_n),
		.si    (second_res),
		.done  (done),
		.result(result)
	);

	// The compensated temperature always stays within its physical bounds.
	`BPTC_ASSERT_SAME(a_temp_range, done,
		(result.temperature_centi >= -20'sd270000) && (result.temperature_centi <= 20'sd140000),
		"compensated temperature out of range")

endmodule

// ===== verif/baro_pressure_temp_compensation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the barometer second-order compensation pipeline.
module baro_pressure_temp_compensation_tb;
	import bptc_pkg::*;

	localparam int PIPE_LATENCY = 9;
	localparam longint COLD_CENTI = 2000;
	localparam longint VERY_COLD_CENTI = -1500;

	// Indexes past the last register; the block must ignore writes to them.
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;

	// With all calibration words zero the pipeline gives zero pascals at 20.00 C.
	localparam out_item_t ZERO_CAL_READING = '{comp_pressure: 32'sd0, temperature_centi: 20'sd2000};

	typedef enum logic [1:0] {
		CAL_ZERO,
		CAL_TYPICAL,
		CAL_FULL,
		CAL_MIXED
	} cal_preset_t;

	typedef struct packed {
		cal_preset_t preset;
		in_item_t    stim;
		logic        typed;
		out_item_t   want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    sample = '0;
	logic        done;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	// Expectation overrides for directed rows whose result is written out by hand.
	logic        want_typed = 1'b0;
	out_item_t   want_fixed = '0;

	out_item_t   pending_readings[$];
	cal_t        cal_shadow = '0;
	int          samples_sent = 0;
	int          readings_checked = 0;
	int          mismatch_count = 0;
	int          sender_idle_pct = 19;

	baro_pressure_temp_compensation DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// Second-order compensation with exact 64-bit integer arithmetic.
	function automatic out_item_t compensate_reading(cal_t c, in_item_t s);
		longint d1, d2, dt, off, sens, temp, t2, off2, sens2, a, b, press;
		out_item_t r;
		d1 = longint'(s.raw_pressure);
		d2 = longint'(s.raw_temperature);
		dt = d2 - longint'(c.reference_temperature) * 256;
		off = longint'(c.pressure_offset) * 65536 + ((longint'(c.offset_temp_coef) * dt) >>> 7);
		sens = longint'(c.pressure_sensitivity) * 32768 + ((longint'(c.sens_temp_coef) * dt) >>> 8);
		temp = COLD_CENTI + ((dt * longint'(c.temp_sensitivity_coef)) >>> 23);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		// Below 20.00 C a quadratic correction applies, with an extra term below -15.00 C.
		if (temp < COLD_CENTI) begin
			a = temp - COLD_CENTI;
			t2 = (dt * dt) >>> 31;
			off2 = (5 * a * a) / 2;
			sens2 = (5 * a * a) / 4;
			if (temp < VERY_COLD_CENTI) begin
				b = temp - VERY_COLD_CENTI;
				off2 = off2 + 7 * b * b;
				sens2 = sens2 + (11 * b * b) / 2;
			end
		end
		temp = temp - t2;
		off = off - off2;
		sens = sens - sens2;
		press = (((d1 * sens) >>> 21) - off) >>> 15;
		r.comp_pressure = press[31:0];
		r.temperature_centi = temp[19:0];
		return r;
	endfunction

	function automatic cal_t preset_cal(cal_preset_t p);
		cal_t c;
		case (p)
			CAL_TYPICAL: c = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
			CAL_FULL: c = '1;
			CAL_MIXED: c = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic directed_row_t dir_row(cal_preset_t p, logic [23:0] d1, logic [23:0] d2,
		logic typed);
		directed_row_t r;
		r.preset = p;
		r.stim.raw_pressure = d1;
		r.stim.raw_temperature = d2;
		r.typed = typed;
		r.want = typed ? ZERO_CAL_READING : '0;
		return r;
	endfunction

	// Each calibration word is an extreme one time in four, otherwise random.
	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Half of the temperatures land near the reference point so the cold branches get exercised.
	function automatic in_item_t random_sample(cal_t c);
		in_item_t s;
		longint t;
		case ($urandom_range(0, 9))
			0: s.raw_pressure = 24'h000000;
			1: s.raw_pressure = 24'hFFFFFF;
			default: s.raw_pressure = 24'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: s.raw_temperature = 24'h000000;
			1: s.raw_temperature = 24'hFFFFFF;
			2, 3, 4: s.raw_temperature = 24'($urandom);
			default: begin
				t = longint'(c.reference_temperature) * 256
					+ longint'($urandom_range(0, 1 << 22)) - (1 << 21);
				if (t < 0)
					t = 0;
				if (t > 24'hFFFFFF)
					t = 24'hFFFFFF;
				s.raw_temperature = t[23:0];
			end
		endcase
		return s;
	endfunction

	// Present one item after a random gap and hold it until the block takes it.
	task automatic send_sample(in_item_t s, logic typed, out_item_t fixed);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		want_typed <= typed;
		want_fixed <= fixed;
		do @(posedge clk); while (busy);
		samples_sent++;
	endtask

	// Stop sending and let every outstanding item come back.
	task automatic wait_drained();
		start <= 1'b0;
		while (readings_checked != samples_sent)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic write_cal(cal_t c);
		cfg_write(CFG_SPARE_6, 16'($urandom));
		cfg_write(CFG_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
		cfg_write(CFG_PRESSURE_OFFSET, c.pressure_offset);
		cfg_write(CFG_SENS_TEMP_COEF, c.sens_temp_coef);
		cfg_write(CFG_OFFSET_TEMP_COEF, c.offset_temp_coef);
		cfg_write(CFG_REFERENCE_TEMPERATURE, c.reference_temperature);
		cfg_write(CFG_TEMP_SENSITIVITY_COEF, c.temp_sensitivity_coef);
		cfg_write(CFG_SPARE_7, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Track calibration writes, queue a prediction per accepted item, check each reading.
	always @(posedge clk) begin : check_readings
		out_item_t want;
		if (arst_n) begin
			if (start && !busy)
				pending_readings.push_back(want_typed ? want_fixed
					: compensate_reading(cal_shadow, sample));
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRESSURE_SENSITIVITY: cal_shadow.pressure_sensitivity = cfg_wdata;
					CFG_PRESSURE_OFFSET: cal_shadow.pressure_offset = cfg_wdata;
					CFG_SENS_TEMP_COEF: cal_shadow.sens_temp_coef = cfg_wdata;
					CFG_OFFSET_TEMP_COEF: cal_shadow.offset_temp_coef = cfg_wdata;
					CFG_REFERENCE_TEMPERATURE: cal_shadow.reference_temperature = cfg_wdata;
					CFG_TEMP_SENSITIVITY_COEF: cal_shadow.temp_sensitivity_coef = cfg_wdata;
					default: ;
				endcase
			end
			if (done) begin
				readings_checked++;
				if (pending_readings.size() == 0) begin
					$error("reading with no item outstanding: comp_pressure %0d, temperature_centi %0d",
						result.comp_pressure, result.temperature_centi);
					mismatch_count++;
				end else begin
					want = pending_readings.pop_front();
					if (result.comp_pressure !== want.comp_pressure) begin
						$error("comp_pressure: expected %0d, actual %0d",
							want.comp_pressure, result.comp_pressure);
						mismatch_count++;
					end
					if (result.temperature_centi !== want.temperature_centi) begin
						$error("temperature_centi: expected %0d, actual %0d",
							want.temperature_centi, result.temperature_centi);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		directed_row_t dir_rows[$];
		cal_preset_t active;
		cal_t cal_now;
		int idle_plan[3];
		idle_plan = '{19, 81, 0};

		// Field extremes with the reset calibration, then the temperature branches and
		// their boundaries under realistic words, then all-ones and lopsided calibrations.
		dir_rows.push_back(dir_row(CAL_ZERO, 24'h000000, 24'h000000, 1'b1));
		dir_rows.push_back(dir_row(CAL_ZERO, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
		dir_rows.push_back(dir_row(CAL_ZERO, 24'hFFFFFF, 24'h000000, 1'b1));
		dir_rows.push_back(dir_row(CAL_ZERO, 24'h000000, 24'hFFFFFF, 1'b1));
		dir_rows.push_back(dir_row(CAL_ZERO, 24'hAAAAAA, 24'h555555, 1'b1));
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'd8569150, 1'b0));
		// Zero temperature difference: exactly 20.00 C, no correction.
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'd8566784, 1'b0));
		// One count below: first cold reading.
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'd8566783, 1'b0));
		// Either side of -15.00 C.
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'd7529764, 1'b0));
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'd7529763, 1'b0));
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'h000000, 1'b0));
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'd9085466, 24'hFFFFFF, 1'b0));
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'h000000, 24'd8569150, 1'b0));
		dir_rows.push_back(dir_row(CAL_TYPICAL, 24'hFFFFFF, 24'd8569150, 1'b0));
		dir_rows.push_back(dir_row(CAL_FULL, 24'h000000, 24'h000000, 1'b0));
		dir_rows.push_back(dir_row(CAL_FULL, 24'hFFFFFF, 24'h000000, 1'b0));
		dir_rows.push_back(dir_row(CAL_FULL, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
		dir_rows.push_back(dir_row(CAL_FULL, 24'h000000, 24'hFFFFFF, 1'b0));
		dir_rows.push_back(dir_row(CAL_FULL, 24'h800000, 24'h800000, 1'b0));
		dir_rows.push_back(dir_row(CAL_MIXED, 24'hFFFFFF, 24'h000000, 1'b0));
		dir_rows.push_back(dir_row(CAL_MIXED, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
		dir_rows.push_back(dir_row(CAL_MIXED, 24'h123456, 24'h000001, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; the calibration is rewritten only when the preset changes.
		active = CAL_ZERO;
		cal_now = preset_cal(active);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].preset != active) begin
				wait_drained();
				active = dir_rows[i].preset;
				cal_now = preset_cal(active);
				write_cal(cal_now);
			end
			send_sample(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random items in blocks of 80, each block under a fresh calibration.
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle_pct = idle_plan[phase];
			for (int blk = 0; blk < 4; blk++) begin
				wait_drained();
				cal_now = '{random_word(), random_word(), random_word(),
					random_word(), random_word(), random_word()};
				write_cal(cal_now);
				repeat (80)
					send_sample(random_sample(cal_now), 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (readings_checked != samples_sent)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		if (pending_readings.size() != 0) begin
			$error("%0d predicted readings never arrived", pending_readings.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bptc_pkg.sv
rtl/core/bptc_first.sv
rtl/core/bptc_second.sv
rtl/core/bptc_press.sv
rtl/core/baro_pressure_temp_compensation.sv
verif/baro_pressure_temp_compensation_tb.sv
